// File: hdl/smqm_pkg.sv
// Shared types, constants and helper functions for the sparse mask query matcher.
`default_nettype none

package smqm_pkg;

  // Fixed field widths of the request and result records.
  localparam int DICT_W  = 64;
  localparam int COMP_W  = 64;
  localparam int FLAG_W  = 8;
  localparam int POS_W   = 32;

  // Width of a population count over one dictionary word (0..64).
  localparam int CNT_W   = $clog2(DICT_W + 1);

  // Default configuration of the matcher.
  localparam int GROUP_SIZE_DEF = 16;
  localparam int GROUPS_DEF     = 4;
  localparam int DICT_BITS_DEF  = 64;
  localparam int INDEX_BITS_DEF = 32;
  localparam int FLAG_BITS_DEF  = 8;

  // Configuration register map.
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_QUERY_DICT  = 2'd0,
    REG_QUERY_BITS  = 2'd1,
    REG_QUERY_FLAGS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DICT_W-1:0] entity_dict;
    logic [COMP_W-1:0] entity_components;
    logic [FLAG_W-1:0] entity_flags;
    logic              last_entity;
  } entity_t;

  typedef struct packed {
    logic             matched;
    logic [POS_W-1:0] entity_position;
    logic             run_start;
    logic             scan_end;
  } result_t;

  // Query as seen by the match pipeline. The guard mask covers every
  // dictionary position below the highest tracked query group.
  typedef struct packed {
    logic [DICT_W-1:0] qdict;
    logic [COMP_W-1:0] qbits;
    logic [FLAG_W-1:0] qflags;
    logic [DICT_W-1:0] guard;
  } query_t;

  // Stage-one outcome handed to the relocation stage.
  typedef struct packed {
    logic              pre_ok;
    logic              bail;
    logic [COMP_W-1:0] comps;
    logic              last;
  } mid_t;

  function automatic logic [63:0] low_mask(input int n);
    logic [63:0] m;
    if (n >= 64) begin
      m = '1;
    end else begin
      m = (64'd1 << n) - 64'd1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: hdl/smqm_cfg.sv
// Query configuration registers and the group position masks derived from them.
`default_nettype none

module smqm_cfg #(
  parameter int GROUPS    = smqm_pkg::GROUPS_DEF,
  parameter int DICT_BITS = smqm_pkg::DICT_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       cfg_write,
  input  wire logic [smqm_pkg::CFG_INDEX_W-1:0]           cfg_index,
  input  wire logic [smqm_pkg::DICT_W-1:0]                cfg_data,
  output smqm_pkg::query_t                                query,
  output logic [GROUPS-1:0][smqm_pkg::DICT_W-1:0]         below
);

  localparam logic [smqm_pkg::DICT_W-1:0] DMASK =
    smqm_pkg::DICT_W'(smqm_pkg::low_mask(DICT_BITS));

  logic [smqm_pkg::DICT_W-1:0]              qd_new;
  logic [smqm_pkg::CNT_W-1:0]               total;
  logic [smqm_pkg::CNT_W-1:0]               ngroups;
  logic [smqm_pkg::DICT_W-1:0][smqm_pkg::CNT_W-1:0] rank;
  logic [GROUPS-1:0][smqm_pkg::DICT_W-1:0]  below_next;
  logic [smqm_pkg::DICT_W-1:0]              guard_next;

  // rank[p] counts the query groups at or below position p; position p lies
  // below query group i exactly when that count does not exceed i.
  always_comb begin
    qd_new  = cfg_data & DMASK;
    total   = smqm_pkg::CNT_W'($countones(qd_new));
    ngroups = (total > smqm_pkg::CNT_W'(GROUPS)) ? smqm_pkg::CNT_W'(GROUPS) : total;
    for (int p = 0; p < smqm_pkg::DICT_W; p++) begin
      rank[p] = smqm_pkg::CNT_W'($countones(qd_new & smqm_pkg::low_mask(p + 1)));
    end
    for (int i = 0; i < GROUPS; i++) begin
      for (int p = 0; p < smqm_pkg::DICT_W; p++) begin
        below_next[i][p] = (smqm_pkg::CNT_W'(i) < total) &&
                           (rank[p] <= smqm_pkg::CNT_W'(i));
      end
    end
    for (int p = 0; p < smqm_pkg::DICT_W; p++) begin
      guard_next[p] = (ngroups != '0) && (rank[p] < ngroups);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query <= '0;
      below <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        smqm_pkg::REG_QUERY_DICT: begin
          query.qdict <= qd_new;
          query.guard <= guard_next;
          below       <= below_next;
        end
        smqm_pkg::REG_QUERY_BITS: begin
          query.qbits <= cfg_data;
        end
        smqm_pkg::REG_QUERY_FLAGS: begin
          query.qflags <= cfg_data[smqm_pkg::FLAG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/smqm_match.sv
// Input register and first match stage: liveness, flags, dictionary cover and shift counts.
`default_nettype none

module smqm_match #(
  parameter int GROUPS    = smqm_pkg::GROUPS_DEF,
  parameter int DICT_BITS = smqm_pkg::DICT_BITS_DEF,
  parameter int FLAG_BITS = smqm_pkg::FLAG_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       in_valid,
  output logic                                            in_ready,
  input  wire smqm_pkg::entity_t                          in_data,
  input  wire smqm_pkg::query_t                           query,
  input  wire logic [GROUPS-1:0][smqm_pkg::DICT_W-1:0]    below,
  input  wire logic                                       down_ready,
  output logic                                            mid_valid,
  output smqm_pkg::mid_t                                  mid,
  output logic [GROUPS-1:0][smqm_pkg::CNT_W-1:0]          mid_cnt
);

  localparam logic [smqm_pkg::DICT_W-1:0] DMASK =
    smqm_pkg::DICT_W'(smqm_pkg::low_mask(DICT_BITS));
  localparam logic [smqm_pkg::FLAG_W-1:0] FMASK =
    smqm_pkg::FLAG_W'(smqm_pkg::low_mask(FLAG_BITS));

  logic                                   s1_valid;
  smqm_pkg::entity_t                      s1;
  logic                                   s1_free;
  logic                                   s2_free;

  logic [smqm_pkg::DICT_W-1:0]            edict;
  logic [smqm_pkg::FLAG_W-1:0]            eflags;
  logic [smqm_pkg::FLAG_W-1:0]            qflags;
  logic [smqm_pkg::DICT_W-1:0]            extra;
  smqm_pkg::mid_t                         mid_next;
  logic [GROUPS-1:0][smqm_pkg::CNT_W-1:0] cnt_next;

  assign s2_free  = !mid_valid || down_ready;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = s1_free;

  always_comb begin
    edict  = s1.entity_dict & DMASK;
    eflags = s1.entity_flags & FMASK;
    qflags = query.qflags & FMASK;
    // Groups the entity holds beyond those of the query.
    extra  = edict ^ query.qdict;
    mid_next.pre_ok = (edict != DMASK) &&
                      ((eflags & qflags) == qflags) &&
                      ((edict & query.qdict) == query.qdict);
    mid_next.bail   = (extra & query.guard) == '0;
    mid_next.comps  = s1.entity_components;
    mid_next.last   = s1.last_entity;
    for (int i = 0; i < GROUPS; i++) begin
      cnt_next[i] = smqm_pkg::CNT_W'($countones(extra & below[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      mid_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= in_valid;
      end
      if (s2_free) begin
        mid_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_free) begin
      s1 <= in_data;
    end
    if (s1_valid && s2_free) begin
      mid     <= mid_next;
      mid_cnt <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/smqm_result.sv
// Second match stage: query bit relocation, component check, scan position and output register.
`default_nettype none

module smqm_result #(
  parameter int GROUP_SIZE = smqm_pkg::GROUP_SIZE_DEF,
  parameter int GROUPS     = smqm_pkg::GROUPS_DEF,
  parameter int INDEX_BITS = smqm_pkg::INDEX_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       mid_valid,
  input  wire smqm_pkg::mid_t                             mid,
  input  wire logic [GROUPS-1:0][smqm_pkg::CNT_W-1:0]     mid_cnt,
  input  wire smqm_pkg::query_t                           query,
  output logic                                            down_ready,
  output logic                                            out_valid,
  input  wire logic                                       out_ready,
  output smqm_pkg::result_t                               out_data
);

  localparam int SHIFT_W = smqm_pkg::CNT_W + $clog2(GROUP_SIZE + 1);

  logic [smqm_pkg::COMP_W-1:0] moved;
  logic [smqm_pkg::COMP_W-1:0] need;
  logic                        match;
  logic                        previous_matched;
  logic [INDEX_BITS-1:0]       position_counter;
  logic                        load;

  assign down_ready = !out_valid || out_ready;
  assign load       = mid_valid && down_ready;

  // Each query group moves up one group slot for every extra entity group
  // below it; bits pushed past the top of the word are lost.
  always_comb begin
    moved = '0;
    for (int i = 0; i < GROUPS; i++) begin
      logic [smqm_pkg::COMP_W-1:0] grp;
      logic [SHIFT_W-1:0]          shamt;
      grp   = query.qbits & (smqm_pkg::low_mask(GROUP_SIZE) << (i * GROUP_SIZE));
      shamt = SHIFT_W'(mid_cnt[i]) * SHIFT_W'(GROUP_SIZE);
      moved = moved | (grp << shamt);
    end
    need  = mid.bail ? query.qbits : moved;
    match = mid.pre_ok && ((mid.comps & need) == need);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      previous_matched <= 1'b0;
      position_counter <= '0;
    end else begin
      if (down_ready) begin
        out_valid <= mid_valid;
      end
      if (load) begin
        if (mid.last) begin
          previous_matched <= 1'b0;
          position_counter <= '0;
        end else begin
          previous_matched <= match;
          position_counter <= position_counter + INDEX_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.matched         <= match;
      out_data.entity_position <= smqm_pkg::POS_W'(position_counter);
      out_data.run_start       <= match && !previous_matched;
      out_data.scan_end        <= mid.last;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sparse_mask_query_matcher.sv
// Top level of the sparse mask query matcher: configuration, two match stages.
// Requests pass the input register, the stage-one register and the output register.
// Throughput: one request per cycle; a stalled output holds the three-deep pipeline.
// Reset (synchronous, active high) empties the pipeline, clears the query registers,
// and returns the scan position and the previous-match mark to zero.
`default_nettype none

module sparse_mask_query_matcher #(
  parameter int GROUP_SIZE = smqm_pkg::GROUP_SIZE_DEF,
  parameter int GROUPS     = smqm_pkg::GROUPS_DEF,
  parameter int DICT_BITS  = smqm_pkg::DICT_BITS_DEF,
  parameter int INDEX_BITS = smqm_pkg::INDEX_BITS_DEF,
  parameter int FLAG_BITS  = smqm_pkg::FLAG_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire smqm_pkg::entity_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output smqm_pkg::result_t                      out_data,
  input  wire logic                              cfg_write,
  input  wire logic [smqm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [smqm_pkg::DICT_W-1:0]       cfg_data
);

  smqm_pkg::query_t                        query;
  logic [GROUPS-1:0][smqm_pkg::DICT_W-1:0] below;
  logic                                    down_ready;
  logic                                    mid_valid;
  smqm_pkg::mid_t                          mid;
  logic [GROUPS-1:0][smqm_pkg::CNT_W-1:0]  mid_cnt;

  smqm_cfg #(
    .GROUPS    (GROUPS),
    .DICT_BITS (DICT_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .query     (query),
    .below     (below)
  );

  smqm_match #(
    .GROUPS    (GROUPS),
    .DICT_BITS (DICT_BITS),
    .FLAG_BITS (FLAG_BITS)
  ) u_match (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .query      (query),
    .below      (below),
    .down_ready (down_ready),
    .mid_valid  (mid_valid),
    .mid        (mid),
    .mid_cnt    (mid_cnt)
  );

  smqm_result #(
    .GROUP_SIZE (GROUP_SIZE),
    .GROUPS     (GROUPS),
    .INDEX_BITS (INDEX_BITS)
  ) u_result (
    .clk        (clk),
    .rst        (rst),
    .mid_valid  (mid_valid),
    .mid        (mid),
    .mid_cnt    (mid_cnt),
    .query      (query),
    .down_ready (down_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// File: hdl/smqm_checker.sv
// Port-level checker for the sparse mask query matcher and its bind statement.
`default_nettype none

module smqm_checker #(
  parameter int INDEX_BITS = smqm_pkg::INDEX_BITS_DEF
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire smqm_pkg::result_t out_data
);

  logic                  in_acc;
  logic                  out_acc;
  logic [2:0]            pending;
  logic [INDEX_BITS-1:0] exp_pos;
  logic                  prev_match;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      exp_pos    <= '0;
      prev_match <= 1'b0;
    end else begin
      pending <= pending + {2'b00, in_acc} - {2'b00, out_acc};
      if (out_acc) begin
        if (out_data.scan_end) begin
          exp_pos    <= '0;
          prev_match <= 1'b0;
        end else begin
          exp_pos    <= exp_pos + INDEX_BITS'(1);
          prev_match <= out_data.matched;
        end
      end
    end
  end

  // A waiting result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Every result belongs to a request that is still in flight.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0 && pending <= 3'd3)
    else $error("result without an outstanding request");

  // Positions count up within a scan and restart after its last entity.
  a_position: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.entity_position == smqm_pkg::POS_W'(exp_pos))
    else $error("entity position out of sequence");

  // A run starts exactly on a match that opens a scan or follows a non-match.
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.run_start == (out_data.matched && !prev_match))
    else $error("run start mark inconsistent with match history");

endmodule

bind sparse_mask_query_matcher smqm_checker #(
  .INDEX_BITS (INDEX_BITS)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the sparse mask query matcher.
module tb;
  import smqm_pkg::*;

  localparam int GSIZE = GROUP_SIZE_DEF;
  localparam int NGROUPS = GROUPS_DEF;
  localparam logic [63:0] GROUP_MASK = (64'd1 << GSIZE) - 64'd1;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES = 8;

  // Tracks the configured query and the scan state, and holds the results that are due.
  class match_tracker;
    logic [63:0] q_dict;
    logic [63:0] q_bits;
    logic [7:0] q_flags;
    logic prev_hit;
    logic [31:0] scan_pos;
    result_t due_results[$];
    int mismatches;

    function new();
      q_dict = '0;
      q_bits = '0;
      q_flags = '0;
      prev_hit = 1'b0;
      scan_pos = '0;
      mismatches = 0;
    endfunction

    // Query bits moved up one group for every extra entity group below them.
    function logic [63:0] relocated_bits(logic [63:0] extra);
      logic [63:0] under[NGROUPS];
      logic [63:0] acc;
      int found;
      int sh;
      found = 0;
      acc = '0;
      for (int g = 0; g < NGROUPS; g++) under[g] = '0;
      for (int p = 0; p < 64 && found < NGROUPS; p++) begin
        if (q_dict[p]) begin
          under[found] = (p == 0) ? 64'd0 : ({64{1'b1}} >> (64 - p));
          found++;
        end
      end
      if (found == 0 || (extra & under[found-1]) == '0) return q_bits;
      for (int g = 0; g < NGROUPS; g++) begin
        sh = $countones(extra & under[g]) * GSIZE;
        if (g * GSIZE < 64 && sh < 64) acc |= (q_bits & (GROUP_MASK << (g * GSIZE))) << sh;
      end
      return acc;
    endfunction

    function void take_entity(entity_t e);
      result_t r;
      logic hit;
      logic [63:0] need;
      hit = 1'b1;
      if (e.entity_dict == '1) begin
        hit = 1'b0;
      end else if ((e.entity_flags & q_flags) != q_flags) begin
        hit = 1'b0;
      end else if ((e.entity_dict & q_dict) != q_dict) begin
        hit = 1'b0;
      end else begin
        need = relocated_bits(e.entity_dict ^ q_dict);
        if ((e.entity_components & need) != need) hit = 1'b0;
      end
      r.matched = hit;
      r.entity_position = scan_pos;
      r.run_start = hit && !prev_hit;
      r.scan_end = e.last_entity;
      due_results.push_back(r);
      if (e.last_entity) begin
        scan_pos = '0;
        prev_hit = 1'b0;
      end else begin
        scan_pos = scan_pos + 32'd1;
        prev_hit = hit;
      end
    endfunction

    function void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10) $display("mismatch in %s: expected %h, got %h", what, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        flag_mismatch("unexpected result", 64'd0, 64'(got));
        return;
      end
      want = due_results.pop_front();
      if (got.matched !== want.matched)
        flag_mismatch("matched", 64'(want.matched), 64'(got.matched));
      if (got.entity_position !== want.entity_position)
        flag_mismatch("entity_position", 64'(want.entity_position), 64'(got.entity_position));
      if (got.run_start !== want.run_start)
        flag_mismatch("run_start", 64'(want.run_start), 64'(got.run_start));
      if (got.scan_end !== want.scan_end)
        flag_mismatch("scan_end", 64'(want.scan_end), 64'(got.scan_end));
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  entity_t in_data;
  logic out_valid;
  logic out_ready;
  result_t out_data;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DICT_W-1:0] cfg_data;

  bit steady;
  int quiet;
  match_tracker tracker = new();

  sparse_mask_query_matcher dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 26);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [5:0] rand_bit64();
    return 6'($urandom_range(0, 63));
  endfunction

  always @(posedge clk) out_ready <= !take_break();

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.take_entity(in_data);
      if (out_valid && out_ready) tracker.check_result(out_data);
    end
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("sparse_mask_query_matcher verification failed");
      $finish;
    end
  end

  task automatic drive_entity(entity_t e);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds off new requests until every result in flight has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_query(logic [63:0] d, logic [63:0] b, logic [7:0] f);
    cfg_write <= 1'b1;
    cfg_index <= REG_QUERY_DICT;
    cfg_data <= d;
    @(posedge clk);
    cfg_index <= REG_QUERY_BITS;
    cfg_data <= b;
    @(posedge clk);
    cfg_index <= REG_QUERY_FLAGS;
    cfg_data <= {56'd0, f};
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.q_dict = d;
    tracker.q_bits = b;
    tracker.q_flags = f;
  endtask

  // A tidy entity covers the query and usually holds the relocated bits; the rest is noise.
  function automatic entity_t compose_entity(bit tidy);
    entity_t e;
    logic [63:0] d;
    int k;
    d = tracker.q_dict;
    k = $urandom_range(0, 3);
    repeat (k) d[rand_bit64()] = 1'b1;
    e.entity_dict = d;
    e.entity_components = tracker.relocated_bits(d ^ tracker.q_dict) | (rand64() & rand64());
    e.entity_flags = tracker.q_flags | 8'($urandom & $urandom);
    e.last_entity = ($urandom_range(0, 19) == 0);
    if (tidy) begin
      if ($urandom_range(0, 4) == 0) e.entity_components[rand_bit64()] = 1'b0;
      if ($urandom_range(0, 9) == 0) e.entity_flags[3'($urandom_range(0, 7))] = 1'b0;
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          e.entity_dict = rand64();
          e.entity_components = rand64();
          e.entity_flags = 8'($urandom);
          e.last_entity = 1'($urandom_range(0, 1));
        end
        1: e.entity_dict[rand_bit64()] = 1'b0;
        default: e.entity_dict = '1;
      endcase
    end
    return e;
  endfunction

  initial begin
    entity_t e;
    logic [63:0] qd;
    logic [63:0] qb;
    logic [7:0] qf;
    int n;
    int phase_len;

    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_QUERY_DICT;
    cfg_data = '0;
    steady = 1'b0;
    quiet = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Two tracked groups; the third packed group has no dictionary bit.
    qd = (64'd1 << 3) | (64'd1 << 10);
    write_query(qd, 64'h0000_8000_0F0F_A5A5, 8'h81);
    drive_entity('{'1, '1, 8'hFF, 1'b0});
    drive_entity('{qd, '1, 8'h01, 1'b0});
    drive_entity('{64'h8, '1, 8'hFF, 1'b0});
    drive_entity('{qd, tracker.q_bits, 8'h81, 1'b0});
    drive_entity('{qd, tracker.q_bits, 8'h81, 1'b0});
    e.entity_dict = qd | 64'h21;
    e.entity_components = tracker.relocated_bits(e.entity_dict ^ qd);
    e.entity_flags = 8'h81;
    e.last_entity = 1'b0;
    drive_entity(e);
    e.entity_components = e.entity_components & (e.entity_components - 64'd1);
    drive_entity(e);
    drive_entity('{qd | (64'd1 << 40), tracker.q_bits, 8'h81, 1'b0});
    // Three extras below everything push the second group past the top.
    e.entity_dict = qd | 64'h7;
    e.entity_components = tracker.relocated_bits(e.entity_dict ^ qd);
    e.last_entity = 1'b1;
    drive_entity(e);
    drive_entity('{64'd0, 64'd0, 8'd0, 1'b1});
    drive_entity('{~64'd1, '1, 8'hFF, 1'b0});
    drive_entity('{qd, 64'd0, 8'h81, 1'b0});
    wait_drained();

    // Six query groups: only the lowest four take part in relocation.
    qd = (64'd1 << 1) | (64'd1 << 4) | (64'd1 << 7) | (64'd1 << 8) | (64'd1 << 30) | (64'd1 << 63);
    write_query(qd, rand64(), 8'd0);
    e.entity_dict = qd | 64'd1;
    e.entity_components = tracker.relocated_bits(e.entity_dict ^ qd);
    e.entity_flags = 8'd0;
    e.last_entity = 1'b0;
    drive_entity(e);
    drive_entity('{qd | (64'd1 << 20), tracker.q_bits, 8'd0, 1'b0});
    drive_entity('{~64'd1, '1, 8'h00, 1'b0});
    drive_entity('{qd, ~tracker.q_bits, 8'hFF, 1'b0});
    drive_entity('{rand64(), rand64(), 8'($urandom), 1'b1});
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      qd = '0;
      case (ph)
        0: begin
          qb = '0;
          qf = '0;
        end
        1: begin
          qd = '1;
          qb = '1;
          qf = 8'hFF;
        end
        default: begin
          n = (ph == 3) ? $urandom_range(NGROUPS + 1, 8) : $urandom_range(1, NGROUPS);
          while ($countones(qd) < n) qd[rand_bit64()] = 1'b1;
          qb = (ph == PHASES - 1) ? '1 : rand64();
          qf = (ph == PHASES - 1) ? 8'hFF : 8'($urandom & $urandom);
        end
      endcase
      write_query(qd, qb, qf);
      steady = (ph == 2);
      phase_len = $urandom_range(80, 120);
      for (int i = 0; i < phase_len; i++) begin
        if (i == phase_len / 2) wait_drained();
        drive_entity(compose_entity($urandom_range(0, 99) < 75));
      end
      wait_drained();
    end
    steady = 1'b0;

    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("sparse_mask_query_matcher verification clean");
    end else begin
      $display("sparse_mask_query_matcher verification failed");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/smqm_pkg.sv
hdl/smqm_cfg.sv
hdl/smqm_match.sv
hdl/smqm_result.sv
hdl/sparse_mask_query_matcher.sv
hdl/smqm_checker.sv
sim/tb.sv
